// ===== hdl/lagged_rotate_xor_random_generator_defines.svh =====
// Assertion helpers, compiled out under SYNTH
`ifndef LAGGED_ROTATE_XOR_RANDOM_GENERATOR_DEFINES_SVH
`define LAGGED_ROTATE_XOR_RANDOM_GENERATOR_DEFINES_SVH

`ifndef SYNTH
`define LRXG_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrxg check failed");
`define LRXG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrxg check failed");
`else
`define LRXG_ASSERT_SAME(lbl, ante, cons)
`define LRXG_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/lrxg_pkg.sv =====
package lrxg_pkg;

    localparam int WORD_W  = 64;
    localparam int PAIRS   = 16;
    localparam int IDX_W   = $clog2(PAIRS);

    localparam int ROT_FIRST_DEF  = 7;
    localparam int ROT_SECOND_DEF = 3;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [IDX_W-1:0]  idx_t;

    typedef enum logic
    {
        FUNC_NEXT = 1'b0,
        FUNC_SEED = 1'b1
    } func_t;

    typedef struct packed
    {
        logic en;
        idx_t addr;
    } ram_rd_t;

    typedef struct packed
    {
        logic  en;
        idx_t  addr;
        word_t data;
    } ram_wr_t;

    function automatic word_t rol(word_t v, int unsigned amt);
        logic [5:0] r;
        r = amt[5:0];
        return (v << r) | (v >> (7'd64 - {1'b0, r}));
    endfunction

    // reset contents of the even words (word 2k)
    function automatic word_t even_init(idx_t k);
        case (k)
            4'd0:    return 64'h4ba36abdd2101f45;
            4'd1:    return 64'h64d3ace9af613b66;
            4'd2:    return 64'hf0891daafe3f9dc7;
            4'd3:    return 64'hb6bf3b95b2df9b65;
            4'd4:    return 64'h899dc6230b46a815;
            4'd5:    return 64'hcf5cd8980a7c06d7;
            4'd6:    return 64'h40d5055ed352d4ae;
            4'd7:    return 64'hd1e58c8c50e29e38;
            4'd8:    return 64'h192a216dd430eb7f;
            4'd9:    return 64'h59f35d5ac1aa2981;
            4'd10:   return 64'h54e622b4fc83c00d;
            4'd11:   return 64'h57e76935fc1a0c6e;
            4'd12:   return 64'h0a38da42aa3bdcb3;
            4'd13:   return 64'h3bb14865eb39354a;
            4'd14:   return 64'h1cb7789893230d4c;
            default: return 64'h1befbf17dd838805;
        endcase
    endfunction

    // odd words (word 2k+1) never change
    function automatic word_t odd_word(idx_t k);
        case (k)
            4'd0:    return 64'h6fe534cd2dfa03c1;
            4'd1:    return 64'he084227d10b2e63b;
            4'd2:    return 64'h769dfe43bcfa4141;
            4'd3:    return 64'h235673bbf5199f3a;
            4'd4:    return 64'h3218aba366f1a731;
            4'd5:    return 64'hc76089f5f18ef3f3;
            4'd6:    return 64'ha5c15365158108bf;
            4'd7:    return 64'h47b89b586e54bb01;
            4'd8:    return 64'h0f7dd278b7855a81;
            4'd9:    return 64'hc68b03f3e69e2149;
            4'd10:   return 64'h92cf04d3c7a040f1;
            4'd11:   return 64'h8f7f8b7fed89075d;
            4'd12:   return 64'hafb12452313261f8;
            4'd13:   return 64'h77e0ae034986274d;
            4'd14:   return 64'h3789c9e12df2b254;
            default: return 64'h78472f6734fa698d;
        endcase
    endfunction

endpackage

// ===== hdl/lrxg_even_ram.sv =====
module lrxg_even_ram
(
    input  logic              clk,
    input  logic              rst_n,
    input  lrxg_pkg::ram_rd_t rd,
    input  lrxg_pkg::ram_wr_t wr,
    output lrxg_pkg::word_t   rd_data
);

    lrxg_pkg::word_t                 mem [lrxg_pkg::PAIRS];
    logic [lrxg_pkg::PAIRS-1:0]      vld_reg;
    logic [lrxg_pkg::PAIRS-1:0]      vld_next;
    lrxg_pkg::word_t                 q_reg;
    lrxg_pkg::word_t                 fwd_data_reg;
    lrxg_pkg::idx_t                  addr_reg;
    logic                            q_vld_reg;
    logic                            fwd_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            q_reg        <= mem[rd.addr];
            addr_reg     <= rd.addr;
            fwd_data_reg <= wr.data;
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (wr.en)
        begin
            vld_next[wr.addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            q_vld_reg <= 1'b0;
            fwd_reg   <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (rd.en)
            begin
                q_vld_reg <= vld_reg[rd.addr];
                fwd_reg   <= wr.en && (wr.addr == rd.addr);
            end
        end
    end

    // write-first on a same-cycle collision; unwritten entries read as reset words
    assign rd_data = fwd_reg   ? fwd_data_reg :
                     q_vld_reg ? q_reg        : lrxg_pkg::even_init(addr_reg);

endmodule

// ===== hdl/lagged_rotate_xor_random_generator.sv =====
// An accepted word is registered in stage 1, then its result in the output register.
// Throughput: one word per cycle unless a held result stalls a NEXT word in stage 1.
// Seed words give no result. A held result blocks input only with a NEXT word in stage 1.
// Reset: pointer and accumulator cleared, RAM valid bits cleared so the even
// words read as their fixed reset values; no clearing pass.
`include "lagged_rotate_xor_random_generator_defines.svh"

module lagged_rotate_xor_random_generator
#(
    parameter int ROT_FIRST  = lrxg_pkg::ROT_FIRST_DEF,
    parameter int ROT_SECOND = lrxg_pkg::ROT_SECOND_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] seed_value
    input  logic        s_axis_tuser,   // [0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [63:0] random_value
);

    lrxg_pkg::ram_rd_t rd;
    lrxg_pkg::ram_wr_t wr;
    lrxg_pkg::word_t   even_word;
    lrxg_pkg::word_t   fresh;

    lrxg_pkg::idx_t    ptr_reg,     ptr_next;
    lrxg_pkg::word_t   acc_reg,     acc_next;
    logic              s1_vld_reg,  s1_vld_next;
    lrxg_pkg::func_t   s1_func_reg;
    lrxg_pkg::idx_t    s1_k_reg;
    lrxg_pkg::word_t   s1_seed_reg;
    logic              out_vld_reg, out_vld_next;
    lrxg_pkg::word_t   out_data_reg;

    logic              accept;
    logic              s1_move;
    logic              s1_is_next;
    lrxg_pkg::func_t   in_func;

    assign in_func    = lrxg_pkg::func_t'(s_axis_tuser);
    assign s1_is_next = (s1_func_reg == lrxg_pkg::FUNC_NEXT);
    assign s1_move    = s1_vld_reg && (!s1_is_next || !out_vld_reg || m_axis_tready);
    assign s_axis_tready = !s1_vld_reg || s1_move;
    assign accept     = s_axis_tvalid && s_axis_tready;

    assign rd.en   = accept && (in_func == lrxg_pkg::FUNC_NEXT);
    assign rd.addr = ptr_reg;

    lrxg_even_ram u_ram
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd      (rd),
        .wr      (wr),
        .rd_data (even_word)
    );

    assign fresh = lrxg_pkg::rol(even_word, ROT_FIRST)
                 ^ lrxg_pkg::rol(lrxg_pkg::odd_word(s1_k_reg), ROT_SECOND);

    always_comb
    begin
        wr.en   = s1_move;
        wr.addr = s1_is_next ? s1_k_reg : '0;
        wr.data = s1_is_next ? fresh    : s1_seed_reg;
    end

    always_comb
    begin
        ptr_next     = ptr_reg;
        acc_next     = acc_reg;
        s1_vld_next  = s1_vld_reg;
        out_vld_next = out_vld_reg;
        if (rd.en)
        begin
            ptr_next = ptr_reg + 1'b1;
        end
        if (accept)
        begin
            s1_vld_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_vld_next = 1'b0;
        end
        if (m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end
        if (s1_move && s1_is_next)
        begin
            acc_next     = acc_reg ^ fresh;
            out_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg     <= '0;
            acc_reg     <= '0;
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            ptr_reg     <= ptr_next;
            acc_reg     <= acc_next;
            s1_vld_reg  <= s1_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg <= in_func;
            s1_k_reg    <= ptr_reg;
            s1_seed_reg <= s_axis_tdata;
        end
        if (s1_move && s1_is_next)
        begin
            out_data_reg <= acc_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

    `LRXG_ASSERT_NEXT(a_next_enters_s1, rd.en, s1_vld_reg && s1_is_next)
    `LRXG_ASSERT_NEXT(a_ptr_step, rd.en, ptr_reg == $past(ptr_reg) + 1'b1)
    `LRXG_ASSERT_NEXT(a_seed_keeps_ptr, accept && !rd.en, $stable(ptr_reg))
    `LRXG_ASSERT_SAME(a_stall_blocks, s1_vld_reg && s1_is_next && out_vld_reg && !m_axis_tready, !s_axis_tready)

endmodule
